FILE: hw/rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: screen geometry,
// character codes, action and state encodings, and the screen memory request.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);

    // field widths of the item and result
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ACT_W  = 2;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CH_BLANK   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_BLOCK   = 8'hDB;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] ATTR_PLAIN = 8'h07;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_BLINK = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_FILL,
        S_PUT,
        S_BLINK,
        S_RDATA
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] attr;
    } t_cell;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_cell             wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_mem_req;

endpackage

FILE: hw/rtl/tcw_screen_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram (
    input  logic            i_clk,
    input  tcw_pkg::t_mem_req i_req,
    output tcw_pkg::t_cell  o_rd_data
);
    import tcw_pkg::*;

    t_cell mem [CELLS];
    t_cell r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/tcw_addr_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_addr_map
// Map a screen row and column to a memory address, through the rotating
// row base that makes a scroll a change of base plus one row fill.
// ----------------------------------------------------------------------------
module tcw_addr_map (
    input  logic [tcw_pkg::ROW_W-1:0]  i_row,
    input  logic [tcw_pkg::COL_W-1:0]  i_col,
    input  logic [tcw_pkg::ROW_W-1:0]  i_base,
    output logic [tcw_pkg::ADDR_W-1:0] o_addr
);
    import tcw_pkg::*;

    localparam int LIN_W = ROW_W + COL_W + 2;

    logic [ROW_W:0]   row_sum;
    logic [ROW_W:0]   phys_row;
    logic [LIN_W-1:0] lin_addr;

    always_comb begin
        row_sum  = {1'b0, i_row} + {1'b0, i_base};
        // both terms stay below ROWS, so one subtract wraps the sum
        phys_row = (row_sum >= (ROW_W+1)'(ROWS)) ? row_sum - (ROW_W+1)'(ROWS) : row_sum;
        lin_addr = LIN_W'(phys_row) * LIN_W'(COLS) + LIN_W'(i_col);
        o_addr   = lin_addr[ADDR_W-1:0];
    end

endmodule

FILE: hw/rtl/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Character-and-attribute text screen with a cursor: put character, clear,
// blink cursor and read cell, over one synchronous cell memory.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake        payload
//  --------  ---------  ---------------  -----------------------------------
//  command   in         start / busy     action, char_code, attr, read_row,
//                                        read_col
//  result    out        o_valid strobe   cursor_y, cursor_x, cell_char,
//                                        cell_attr, did_scroll
//
//  Per item: put without scroll, newline, out-of-range read and blink with
//  a scroll pending finish straight from idle; read and blink add one memory
//  read turn; put with a pending scroll first does one row fill on the
//  single write port; clear does one write per cell.
//  Reset: after i_rst_n is released the block runs a clearing pass over all
//  CELLS = 2000 cells with busy high before it takes the first item.
//  The result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module text_console_writer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tcw_pkg::ACT_W-1:0]   i_action,
    input  logic [tcw_pkg::BYTE_W-1:0]  i_char_code,
    input  logic [tcw_pkg::BYTE_W-1:0]  i_attr,
    input  logic [tcw_pkg::ROW_W-1:0]   i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]   i_read_col,
    output logic                        o_valid,
    output logic [tcw_pkg::ROW_W-1:0]   o_cursor_y,
    output logic [tcw_pkg::COL_W-1:0]   o_cursor_x,
    output logic [tcw_pkg::BYTE_W-1:0]  o_cell_char,
    output logic [tcw_pkg::BYTE_W-1:0]  o_cell_attr,
    output logic                        o_did_scroll
);
    import tcw_pkg::*;

    // control state
    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_row,   n_row;     // cursor row, ROWS = scroll pending
    logic [COL_W-1:0]   r_col,   n_col;
    logic [ROW_W-1:0]   r_base,  n_base;    // physical row holding screen row 0
    logic [ADDR_W-1:0]  r_cnt,   n_cnt;     // sweep / fill position
    logic               r_clr_rsp, n_clr_rsp;
    logic               r_valid, n_valid;

    // held item payload for the multi-cycle put
    logic [BYTE_W-1:0]  r_char,  n_char;
    logic [BYTE_W-1:0]  r_attr,  n_attr;

    // result registers
    logic [ROW_W-1:0]   r_res_y,    n_res_y;
    logic [COL_W-1:0]   r_res_x,    n_res_x;
    logic [BYTE_W-1:0]  r_res_char, n_res_char;
    logic [BYTE_W-1:0]  r_res_attr, n_res_attr;
    logic               r_res_scr,  n_res_scr;

    // datapath
    t_mem_req           mem_req;
    t_cell              rd_cell;
    t_cell              blink_cell;
    logic [COL_W-1:0]   cur_col_sel;
    logic [ADDR_W-1:0]  cur_addr;
    logic [ADDR_W-1:0]  read_addr;
    logic [BYTE_W-1:0]  put_ch;
    logic [BYTE_W-1:0]  put_at;
    logic [ROW_W-1:0]   adv_row;
    logic [COL_W-1:0]   adv_col;
    logic               read_in_range;

    // ------------------------------------------------------------------
    // Address mapping: cursor cell (or fill column) and the read cell
    // ------------------------------------------------------------------
    assign cur_col_sel = (r_state == S_FILL) ? r_cnt[COL_W-1:0] : r_col;

    tcw_addr_map u_cur_map (
        .i_row  (r_row),
        .i_col  (cur_col_sel),
        .i_base (r_base),
        .o_addr (cur_addr)
    );

    tcw_addr_map u_rd_map (
        .i_row  (i_read_row),
        .i_col  (i_read_col),
        .i_base (r_base),
        .o_addr (read_addr)
    );

    tcw_screen_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_cell)
    );

    // ------------------------------------------------------------------
    // Put step: character source and cursor advance
    // ------------------------------------------------------------------
    always_comb begin
        put_ch = (r_state == S_IDLE) ? i_char_code : r_char;
        put_at = (r_state == S_IDLE) ? i_attr      : r_attr;
        if (put_ch == CH_NEWLINE) begin
            adv_row = r_row + 1'b1;
            adv_col = '0;
        end else if (r_col == COL_W'(COLS - 1)) begin
            adv_row = r_row + 1'b1;
            adv_col = '0;
        end else begin
            adv_row = r_row;
            adv_col = r_col + 1'b1;
        end
    end

    // blink toggles a blank into a solid block, anything else into a blank
    always_comb begin
        if (rd_cell.ch == CH_BLANK) begin
            blink_cell.ch   = CH_BLOCK;
            blink_cell.attr = ATTR_PLAIN;
        end else begin
            blink_cell.ch   = CH_BLANK;
            blink_cell.attr = rd_cell.attr;
        end
    end

    assign read_in_range = (i_read_row < ROW_W'(ROWS)) && (i_read_col < COL_W'(COLS));

    // ------------------------------------------------------------------
    // Next state and memory requests
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_base     = r_base;
        n_cnt      = r_cnt;
        n_clr_rsp  = r_clr_rsp;
        n_char     = r_char;
        n_attr     = r_attr;
        n_valid    = 1'b0;
        n_res_y    = r_res_y;
        n_res_x    = r_res_x;
        n_res_char = r_res_char;
        n_res_attr = r_res_attr;
        n_res_scr  = r_res_scr;
        mem_req    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_char = i_char_code;
                    n_attr = i_attr;
                    unique case (t_action'(i_action))
                        ACT_PUT: begin
                            if (r_row == ROW_W'(ROWS)) begin
                                // rotate the base: the old top row becomes the
                                // new bottom row, then fill it
                                n_base  = (r_base == ROW_W'(ROWS - 1)) ? '0 : r_base + 1'b1;
                                n_row   = ROW_W'(ROWS - 1);
                                n_col   = '0;
                                n_cnt   = '0;
                                n_state = S_FILL;
                            end else begin
                                if (put_ch != CH_NEWLINE) begin
                                    mem_req.wr_en   = 1'b1;
                                    mem_req.wr_addr = cur_addr;
                                    mem_req.wr_data = '{ch: put_ch, attr: put_at};
                                end
                                n_row      = adv_row;
                                n_col      = adv_col;
                                n_valid    = 1'b1;
                                n_res_y    = adv_row;
                                n_res_x    = adv_col;
                                n_res_char = '0;
                                n_res_attr = '0;
                                n_res_scr  = 1'b0;
                            end
                        end
                        ACT_CLEAR: begin
                            n_state   = S_SWEEP;
                            n_cnt     = '0;
                            n_clr_rsp = 1'b1;
                            n_row     = '0;
                            n_col     = '0;
                            n_base    = '0;
                        end
                        ACT_BLINK: begin
                            if (r_row < ROW_W'(ROWS)) begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = cur_addr;
                                n_state         = S_BLINK;
                            end else begin
                                n_valid    = 1'b1;
                                n_res_y    = r_row;
                                n_res_x    = r_col;
                                n_res_char = '0;
                                n_res_attr = '0;
                                n_res_scr  = 1'b0;
                            end
                        end
                        ACT_READ: begin
                            if (read_in_range) begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = read_addr;
                                n_state         = S_RDATA;
                            end else begin
                                n_valid    = 1'b1;
                                n_res_y    = r_row;
                                n_res_x    = r_col;
                                n_res_char = '0;
                                n_res_attr = '0;
                                n_res_scr  = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_SWEEP: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_cnt;
                mem_req.wr_data = '{ch: CH_BLANK, attr: ATTR_PLAIN};
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == ADDR_W'(CELLS - 1)) begin
                    n_state   = S_IDLE;
                    n_clr_rsp = 1'b0;
                    // the pass after reset gives no result
                    if (r_clr_rsp) begin
                        n_valid    = 1'b1;
                        n_res_y    = r_row;
                        n_res_x    = r_col;
                        n_res_char = '0;
                        n_res_attr = '0;
                        n_res_scr  = 1'b0;
                    end
                end
            end

            S_FILL: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cur_addr;
                mem_req.wr_data = '{ch: CH_BLANK, attr: r_attr};
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == ADDR_W'(COLS - 1)) begin
                    n_state = S_PUT;
                end
            end

            S_PUT: begin
                if (put_ch != CH_NEWLINE) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = cur_addr;
                    mem_req.wr_data = '{ch: put_ch, attr: put_at};
                end
                n_row      = adv_row;
                n_col      = adv_col;
                n_state    = S_IDLE;
                n_valid    = 1'b1;
                n_res_y    = adv_row;
                n_res_x    = adv_col;
                n_res_char = '0;
                n_res_attr = '0;
                n_res_scr  = 1'b1;
            end

            S_BLINK: begin
                // write back the toggled cell read in the previous cycle
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cur_addr;
                mem_req.wr_data = blink_cell;
                n_state         = S_IDLE;
                n_valid         = 1'b1;
                n_res_y         = r_row;
                n_res_x         = r_col;
                n_res_char      = '0;
                n_res_attr      = '0;
                n_res_scr       = 1'b0;
            end

            S_RDATA: begin
                n_state    = S_IDLE;
                n_valid    = 1'b1;
                n_res_y    = r_row;
                n_res_x    = r_col;
                n_res_char = rd_cell.ch;
                n_res_attr = rd_cell.attr;
                n_res_scr  = 1'b0;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_row     <= '0;
            r_col     <= '0;
            r_base    <= '0;
            r_cnt     <= '0;
            r_clr_rsp <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_col     <= n_col;
            r_base    <= n_base;
            r_cnt     <= n_cnt;
            r_clr_rsp <= n_clr_rsp;
            r_valid   <= n_valid;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_attr     <= n_attr;
        r_res_y    <= n_res_y;
        r_res_x    <= n_res_x;
        r_res_char <= n_res_char;
        r_res_attr <= n_res_attr;
        r_res_scr  <= n_res_scr;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_cursor_y   = r_res_y;
    assign o_cursor_x   = r_res_x;
    assign o_cell_char  = r_res_char;
    assign o_cell_attr  = r_res_attr;
    assign o_did_scroll = r_res_scr;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= ROW_W'(ROWS)) && (r_col < COL_W'(COLS)))
        else $error("cursor outside the screen");

    a_rd_turn_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLINK || r_state == S_RDATA) |=> (o_valid && !busy))
        else $error("read turn did not end in a result");

    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_CLEAR) |=> (busy && !o_valid))
        else $error("clear did not start a sweep");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDATA) |-> !mem_req.wr_en)
        else $error("write during a cell read turn");

endmodule

FILE: tb/text_console_writer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_test
// Drives put, clear, blink and read commands into the text console writer and
// checks every result against a shadow copy of the screen and the cursor.
// ----------------------------------------------------------------------------
module text_console_writer_test;

    import tcw_pkg::*;

    // One command as presented on the input ports.
    typedef struct packed {
        t_action           action;
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] attr;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_console_cmd;

    // What the block reports after one command.
    typedef struct packed {
        logic [ROW_W-1:0]  cursor_y;
        logic [COL_W-1:0]  cursor_x;
        logic [BYTE_W-1:0] cell_char;
        logic [BYTE_W-1:0] cell_attr;
        logic              did_scroll;
    } t_console_view;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  start        = 1'b0;
    logic [ACT_W-1:0]      i_action     = '0;
    logic [BYTE_W-1:0]     i_char_code  = '0;
    logic [BYTE_W-1:0]     i_attr       = '0;
    logic [ROW_W-1:0]      i_read_row   = '0;
    logic [COL_W-1:0]      i_read_col   = '0;
    logic                  busy;
    logic                  o_valid;
    logic [ROW_W-1:0]      o_cursor_y;
    logic [COL_W-1:0]      o_cursor_x;
    logic [BYTE_W-1:0]     o_cell_char;
    logic [BYTE_W-1:0]     o_cell_attr;
    logic                  o_did_scroll;

    // Commands waiting to be driven, and views predicted for accepted ones.
    t_console_cmd  cmd_queue[$];
    t_console_view view_queue[$];

    // Shadow screen and cursor, advanced once per accepted command.
    logic [BYTE_W-1:0] shadow_chars[CELLS];
    logic [BYTE_W-1:0] shadow_attrs[CELLS];
    int                shadow_row;
    int                shadow_col;

    int issued_cnt    = 0;
    int accepted_cnt  = 0;
    int send_idle_pct = 0;
    int errors        = 0;

    text_console_writer u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_char_code  (i_char_code),
        .i_attr       (i_attr),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_valid      (o_valid),
        .o_cursor_y   (o_cursor_y),
        .o_cursor_x   (o_cursor_x),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_did_scroll (o_did_scroll)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Print one line per mismatch and count it.
    task automatic flag_error(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    // Apply one command to the shadow screen and return the view it leaves.
    function automatic t_console_view next_console_view(input t_console_cmd cmd);
        t_console_view view;
        int            idx;
        view = '0;
        case (cmd.action)
            ACT_PUT: begin
                // A pending scroll is taken before the character is handled:
                // shift rows up, blank the bottom row in the given attribute.
                if (shadow_row >= ROWS) begin
                    for (int i = 0; i < CELLS - COLS; i++) begin
                        shadow_chars[i] = shadow_chars[i + COLS];
                        shadow_attrs[i] = shadow_attrs[i + COLS];
                    end
                    for (int c = 0; c < COLS; c++) begin
                        shadow_chars[(ROWS - 1) * COLS + c] = CH_BLANK;
                        shadow_attrs[(ROWS - 1) * COLS + c] = cmd.attr;
                    end
                    shadow_row      = ROWS - 1;
                    shadow_col      = 0;
                    view.did_scroll = 1'b1;
                end
                if (cmd.ch == CH_NEWLINE) begin
                    shadow_row++;
                    shadow_col = 0;
                end else begin
                    idx = shadow_row * COLS + shadow_col;
                    shadow_chars[idx] = cmd.ch;
                    shadow_attrs[idx] = cmd.attr;
                    shadow_col++;
                    if (shadow_col >= COLS) begin
                        shadow_col = 0;
                        shadow_row++;
                    end
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < CELLS; i++) begin
                    shadow_chars[i] = CH_BLANK;
                    shadow_attrs[i] = ATTR_PLAIN;
                end
                shadow_row = 0;
                shadow_col = 0;
            end
            ACT_BLINK: begin
                // Nothing to toggle while the cursor sits below the last row.
                if (shadow_row < ROWS) begin
                    idx = shadow_row * COLS + shadow_col;
                    if (shadow_chars[idx] == CH_BLANK) begin
                        shadow_chars[idx] = CH_BLOCK;
                        shadow_attrs[idx] = ATTR_PLAIN;
                    end else begin
                        shadow_chars[idx] = CH_BLANK;
                    end
                end
            end
            default: begin
                // Read: cells off the screen report zero.
                if (cmd.row < ROWS && cmd.col < COLS) begin
                    idx = int'(cmd.row) * COLS + int'(cmd.col);
                    view.cell_char = shadow_chars[idx];
                    view.cell_attr = shadow_attrs[idx];
                end
            end
        endcase
        view.cursor_y = ROW_W'(shadow_row);
        view.cursor_x = COL_W'(shadow_col);
        return view;
    endfunction

    // Random command: puts dominate and carry many newlines so the screen
    // fills and scrolls often; clears are rare since each sweeps the store.
    function automatic t_console_cmd random_command();
        t_console_cmd cmd;
        int           pick;
        pick = $urandom_range(999);
        if (pick < 4) begin
            cmd.action = ACT_CLEAR;
        end else if (pick < 110) begin
            cmd.action = ACT_BLINK;
        end else if (pick < 280) begin
            cmd.action = ACT_READ;
        end else begin
            cmd.action = ACT_PUT;
        end
        cmd.ch   = ($urandom_range(99) < 30) ? CH_NEWLINE : BYTE_W'($urandom);
        cmd.attr = BYTE_W'($urandom);
        // Mostly on-screen reads; the rest take any bit pattern.
        if ($urandom_range(99) < 80) begin
            cmd.row = ROW_W'($urandom_range(ROWS - 1));
            cmd.col = COL_W'($urandom_range(COLS - 1));
        end else begin
            cmd.row = ROW_W'($urandom);
            cmd.col = COL_W'($urandom);
        end
        return cmd;
    endfunction

    task automatic push_cmd(input t_action act, input logic [BYTE_W-1:0] ch,
                            input logic [BYTE_W-1:0] attr, input int row, input int col);
        t_console_cmd cmd;
        cmd.action = act;
        cmd.ch     = ch;
        cmd.attr   = attr;
        cmd.row    = ROW_W'(row);
        cmd.col    = COL_W'(col);
        cmd_queue.push_back(cmd);
    endtask

    // Driver: change inputs on the falling edge. Once the presented command
    // has been taken (or none is up), either idle or present the next one.
    always @(negedge i_clk) begin
        t_console_cmd cmd;
        if (i_rst_n && accepted_cnt == issued_cnt) begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cmd = cmd_queue.pop_front();
                i_action    <= cmd.action;
                i_char_code <= cmd.ch;
                i_attr      <= cmd.attr;
                i_read_row  <= cmd.row;
                i_read_col  <= cmd.col;
                start       <= 1'b1;
                issued_cnt++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: on the rising edge, check any result against the oldest
    // prediction first, then predict for a command taken at this edge.
    always @(posedge i_clk) begin
        t_console_view want;
        t_console_cmd  cmd;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (view_queue.size() == 0) begin
                    flag_error("result strobe with no command outstanding");
                end else begin
                    want = view_queue.pop_front();
                    if (o_cursor_y !== want.cursor_y) begin
                        flag_error($sformatf("cursor_y got %0d want %0d",
                                             o_cursor_y, want.cursor_y));
                    end
                    if (o_cursor_x !== want.cursor_x) begin
                        flag_error($sformatf("cursor_x got %0d want %0d",
                                             o_cursor_x, want.cursor_x));
                    end
                    if (o_cell_char !== want.cell_char) begin
                        flag_error($sformatf("cell_char got %h want %h",
                                             o_cell_char, want.cell_char));
                    end
                    if (o_cell_attr !== want.cell_attr) begin
                        flag_error($sformatf("cell_attr got %h want %h",
                                             o_cell_attr, want.cell_attr));
                    end
                    if (o_did_scroll !== want.did_scroll) begin
                        flag_error($sformatf("did_scroll got %b want %b",
                                             o_did_scroll, want.did_scroll));
                    end
                end
            end else if (o_valid !== 1'b0) begin
                flag_error("result strobe unknown");
            end
            if (start && busy === 1'b0) begin
                cmd.action = t_action'(i_action);
                cmd.ch     = i_char_code;
                cmd.attr   = i_attr;
                cmd.row    = i_read_row;
                cmd.col    = i_read_col;
                view_queue.push_back(next_console_view(cmd));
                accepted_cnt++;
            end
        end
    end

    // Watchdog: far beyond the slowest legal run, even with every command a
    // clear and the clearing pass included.
    initial begin
        #100ms;
        $display("text_console_writer_test: errors");
        $finish;
    end

    initial begin
        // Shadow state matches the block after reset.
        for (int i = 0; i < CELLS; i++) begin
            shadow_chars[i] = CH_BLANK;
            shadow_attrs[i] = ATTR_PLAIN;
        end
        shadow_row = 0;
        shadow_col = 0;

        // Directed: reads at the screen corners and off the screen, blink on
        // a blank and on a block, puts at the byte extremes, newline, clear.
        push_cmd(ACT_READ,  8'h00, 8'h00, 0, 0);
        push_cmd(ACT_READ,  8'h00, 8'h00, ROWS - 1, COLS - 1);
        push_cmd(ACT_READ,  8'hFF, 8'hFF, 31, 127);
        push_cmd(ACT_READ,  8'h00, 8'h00, ROWS, 0);
        push_cmd(ACT_READ,  8'h00, 8'h00, 0, COLS);
        push_cmd(ACT_BLINK, 8'h00, 8'h00, 0, 0);
        push_cmd(ACT_READ,  8'h00, 8'h00, 0, 0);
        push_cmd(ACT_BLINK, 8'h00, 8'h00, 0, 0);
        push_cmd(ACT_PUT,   8'h41, 8'hFF, 0, 0);
        push_cmd(ACT_PUT,   8'h00, 8'h00, 0, 0);
        push_cmd(ACT_PUT,   8'hFF, 8'hF0, 0, 0);
        push_cmd(ACT_READ,  8'h00, 8'h00, 0, 0);
        push_cmd(ACT_READ,  8'h00, 8'h00, 0, 2);
        push_cmd(ACT_PUT,   CH_NEWLINE, 8'h5A, 0, 0);
        push_cmd(ACT_BLINK, 8'h00, 8'h00, 0, 0);
        push_cmd(ACT_READ,  8'h00, 8'h00, 1, 0);
        push_cmd(ACT_CLEAR, 8'h00, 8'h00, 0, 0);
        push_cmd(ACT_READ,  8'h00, 8'h00, 0, 0);
        push_cmd(ACT_READ,  8'h00, 8'h00, 1, 0);

        // Three random phases: idle sender, busier idling, then back to back.
        send_idle_pct = 29;
        repeat (520) cmd_queue.push_back(random_command());

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0) @(posedge i_clk);
        send_idle_pct = 49;
        repeat (520) cmd_queue.push_back(random_command());
        while (cmd_queue.size() != 0) @(posedge i_clk);
        send_idle_pct = 0;
        repeat (510) cmd_queue.push_back(random_command());
        while (cmd_queue.size() != 0) @(posedge i_clk);

        // Drain: every taken command must report, then hold a little longer
        // to catch stray strobes.
        while (accepted_cnt != issued_cnt || view_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (view_queue.size() != 0) begin
            flag_error("predicted results left unreported");
        end

        if (errors == 0) begin
            $display("text_console_writer_test: clean");
        end else begin
            $display("text_console_writer_test: errors");
        end
        $finish;
    end

endmodule
